### rtl/core/stack_region_allocator_macros.svh
// assertion macros for the stack region allocator
`ifndef STACK_REGION_ALLOCATOR_MACROS_SVH
`define STACK_REGION_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SRA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SRA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SRA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define SRA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

### rtl/core/sra_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sra_pkg;

    localparam int ADDR_W    = 32;
    localparam int ALIGN_W   = 13;
    localparam int ALIGN_MAX = 4096;
    localparam int DIV_CNT_W = $clog2(ADDR_W);

    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [ALIGN_W-1:0] align_t;

    // request kinds
    localparam logic [1:0] K_ALLOC   = 2'd0;
    localparam logic [1:0] K_TRUNC   = 2'd1;
    localparam logic [1:0] K_DEALLOC = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_BAD     = 2'd2;

    // configuration register indexes
    localparam logic REG_BOTTOM = 1'b0;
    localparam logic REG_TOP    = 1'b1;

    // remainder unit status
    typedef struct packed {
        logic busy;
        logic done;
    } sra_div_stat_t;

endpackage

`default_nettype wire

### rtl/core/sra_rem_unit.sv
`timescale 1ns / 1ps
`default_nettype none

`include "stack_region_allocator_macros.svh"

module sra_rem_unit (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire sra_pkg::addr_t        dividend,
    input  wire sra_pkg::align_t       divisor,
    output sra_pkg::sra_div_stat_t     stat,
    output sra_pkg::align_t            rem
);
    import sra_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    addr_t                dvd_reg, dvd_next;
    align_t               dsr_reg, dsr_next;
    align_t               rem_reg, rem_next;
    logic [ALIGN_W:0]     trial;

    // restoring remainder, one dividend bit per cycle, msb first
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, dvd_reg[ADDR_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
                rem_next = ALIGN_W'(trial - {1'b0, dsr_reg});
            else
                rem_next = trial[ALIGN_W-1:0];
            dvd_next = {dvd_reg[ADDR_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(ADDR_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign rem       = rem_reg;

    `SRA_ASSERT_NOW(a_rem_below_divisor, clk, rst_n, busy_reg && cnt_reg != '0, rem_reg < dsr_reg, "partial remainder not below divisor")
    `SRA_ASSERT_NEXT(a_start_busy, clk, rst_n, start, busy_reg, "start did not raise busy")
    `SRA_ASSERT_NEXT(a_done_pulse, clk, rst_n, done_reg, !done_reg && !busy_reg, "done longer than one cycle")

endmodule

`default_nettype wire

### rtl/core/stack_region_allocator.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake            payload
// in        input      in_valid/in_ready    kind, block_addr, block_size, new_size, align
// out       output     out_valid/out_ready  status, result_addr, result_size, used_bytes
// cfg       input      cfg_wr_en            cfg_index, cfg_data (write only, no wait)
//
// allocate with a legal alignment waits in the bit-serial remainder unit
// (used % align) until its done pulse, then goes through prepare and evaluate;
// other requests go straight to prepare and evaluate
// one request is in flight at a time; in_ready is low from transfer until the
// result is loaded into the output register
// a result held by out_ready low stalls the evaluate step until the output frees
// reset clears all pointers, both region registers and the output valid

`include "stack_region_allocator_macros.svh"

module stack_region_allocator (
    input  wire logic            clk,
    input  wire logic            rst_n,
    // request channel
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [1:0]      kind,
    input  wire sra_pkg::addr_t  block_addr,
    input  wire sra_pkg::addr_t  block_size,
    input  wire sra_pkg::addr_t  new_size,
    input  wire sra_pkg::align_t align,
    // result channel
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic [1:0]           status,
    output sra_pkg::addr_t       result_addr,
    output sra_pkg::addr_t       result_size,
    output sra_pkg::addr_t       used_bytes,
    // configuration writes
    input  wire logic            cfg_wr_en,
    input  wire logic            cfg_index,
    input  wire sra_pkg::addr_t  cfg_data
);
    import sra_pkg::*;

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_PREP = 2'd2;
    localparam logic [1:0] S_EXEC = 2'd3;

    logic [1:0] state_reg, state_next;

    // region and allocator state
    addr_t bottom_reg, bottom_next;
    addr_t rtop_reg, rtop_next;
    addr_t top_ptr_reg, top_ptr_next;
    addr_t low_mark_reg, low_mark_next;
    addr_t live_reg, live_next;

    // captured request
    logic [1:0] kind_reg;
    addr_t      addr_reg;
    addr_t      size_reg;
    addr_t      nsize_reg;
    align_t     align_reg;

    // prepared operands
    align_t        pad_reg;
    addr_t         avail_reg;
    addr_t         amt_reg;
    logic [ADDR_W:0] end_reg;

    // output register
    logic       out_valid_reg, out_valid_next;
    logic [1:0] status_reg;
    addr_t      result_addr_reg;
    addr_t      result_size_reg;
    addr_t      used_bytes_reg;

    // remainder unit hookup
    sra_div_stat_t div_stat;
    align_t        div_rem;
    logic          div_start;
    logic          in_fire;
    logic          align_ok_in;
    logic          align_ok;

    // evaluate step results
    logic       exec_fire;
    logic [1:0] ev_status;
    addr_t      ev_addr;
    addr_t      ev_size;
    addr_t      ev_top;
    addr_t      ev_low;
    addr_t      ev_live;
    addr_t      pad_ext;
    addr_t      grow;
    addr_t      end_a;
    logic       end_ovf;
    logic       range_bad;

    assign in_ready    = (state_reg == S_IDLE);
    assign in_fire     = in_valid && in_ready;
    assign align_ok_in = (align != '0) && (align <= ALIGN_W'(ALIGN_MAX));
    assign align_ok    = (align_reg != '0) && (align_reg <= ALIGN_W'(ALIGN_MAX));
    // only a legal allocate needs the remainder of the used size
    assign div_start   = in_fire && (kind == K_ALLOC) && align_ok_in;

    sra_rem_unit u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (top_ptr_reg - bottom_reg),
        .divisor  (align),
        .stat     (div_stat),
        .rem      (div_rem)
    );

    // evaluate: decide the outcome and the new pointers
    assign pad_ext   = {{(ADDR_W-ALIGN_W){1'b0}}, pad_reg};
    assign grow      = size_reg + pad_ext;
    assign end_a     = end_reg[ADDR_W-1:0];
    assign end_ovf   = end_reg[ADDR_W];
    // block must lie within bottom..top and inside the address range
    assign range_bad = (addr_reg < bottom_reg) || end_ovf || (end_a > top_ptr_reg);
    assign exec_fire = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);

    always_comb
    begin
        ev_status = ST_OK;
        ev_addr   = '0;
        ev_size   = '0;
        ev_top    = top_ptr_reg;
        ev_low    = low_mark_reg;
        ev_live   = live_reg;
        case (kind_reg)
            K_ALLOC:
            begin
                if (!align_ok)
                    ev_status = ST_BAD;
                else if ((size_reg > avail_reg) || (pad_ext > avail_reg - size_reg))
                    ev_status = ST_NOSPACE;
                else
                begin
                    ev_addr = top_ptr_reg + pad_ext;
                    ev_size = size_reg;
                    ev_top  = top_ptr_reg + grow;
                    // hole-free prefix keeps growing while mark sits at top
                    if (low_mark_reg == top_ptr_reg)
                        ev_low  = top_ptr_reg + grow;
                    else
                        ev_live = live_reg + grow;
                end
            end
            K_TRUNC:
            begin
                if ((nsize_reg > size_reg) || range_bad)
                    ev_status = ST_BAD;
                else
                begin
                    ev_addr = addr_reg;
                    ev_size = nsize_reg;
                    // space returns only when the block ends at top
                    if (end_a == top_ptr_reg)
                    begin
                        if (low_mark_reg == top_ptr_reg)
                        begin
                            ev_low = low_mark_reg - amt_reg;
                            ev_top = top_ptr_reg - amt_reg;
                        end
                        else if (live_reg < amt_reg)
                        begin
                            ev_status = ST_BAD;
                            ev_addr   = '0;
                            ev_size   = '0;
                        end
                        else
                        begin
                            ev_live = live_reg - amt_reg;
                            ev_top  = top_ptr_reg - amt_reg;
                        end
                    end
                end
            end
            K_DEALLOC:
            begin
                if (range_bad)
                    ev_status = ST_BAD;
                else
                begin
                    if (end_a == top_ptr_reg)
                    begin
                        // pop the top block
                        if (low_mark_reg == top_ptr_reg)
                        begin
                            ev_low = low_mark_reg - amt_reg;
                            ev_top = top_ptr_reg - amt_reg;
                        end
                        else if (live_reg < amt_reg)
                            ev_status = ST_BAD;
                        else
                        begin
                            ev_live = live_reg - amt_reg;
                            ev_top  = top_ptr_reg - amt_reg;
                        end
                    end
                    else if (end_a == low_mark_reg)
                        ev_low = low_mark_reg - amt_reg;
                    else if (end_a > low_mark_reg)
                    begin
                        // hole above the mark
                        if (live_reg < amt_reg)
                            ev_status = ST_BAD;
                        else
                            ev_live = live_reg - amt_reg;
                    end
                    else
                    begin
                        // block below the mark: mark drops, gap counts as live
                        ev_live = live_reg + (low_mark_reg - addr_reg) - amt_reg;
                        ev_low  = addr_reg;
                    end
                    // nothing live above mark: top falls back to it
                    if (ev_status == ST_OK && ev_live == '0)
                        ev_top = ev_low;
                    if (ev_status != ST_OK)
                    begin
                        ev_top  = top_ptr_reg;
                        ev_low  = low_mark_reg;
                        ev_live = live_reg;
                    end
                end
            end
            default:
                ev_status = ST_BAD;
        endcase
    end

    // sequencer and state update
    always_comb
    begin
        state_next     = state_reg;
        bottom_next    = bottom_reg;
        rtop_next      = rtop_reg;
        top_ptr_next   = top_ptr_reg;
        low_mark_next  = low_mark_reg;
        live_next      = live_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                    state_next = div_start ? S_DIV : S_PREP;
            end
            S_DIV:
            begin
                if (div_stat.done)
                    state_next = S_PREP;
            end
            S_PREP:
                state_next = S_EXEC;
            S_EXEC:
            begin
                if (exec_fire)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    top_ptr_next   = ev_top;
                    low_mark_next  = ev_low;
                    live_next      = ev_live;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
        // region writes are for the user to make only while idle; the block does not enforce it
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_BOTTOM:
                begin
                    bottom_next   = cfg_data;
                    top_ptr_next  = cfg_data;
                    low_mark_next = cfg_data;
                    live_next     = '0;
                end
                REG_TOP:
                    rtop_next = cfg_data;
                default:
                    rtop_next = rtop_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bottom_reg    <= '0;
            rtop_reg      <= '0;
            top_ptr_reg   <= '0;
            low_mark_reg  <= '0;
            live_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bottom_reg    <= bottom_next;
            rtop_reg      <= rtop_next;
            top_ptr_reg   <= top_ptr_next;
            low_mark_reg  <= low_mark_next;
            live_reg      <= live_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // request capture, operand prep and result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            kind_reg  <= kind;
            addr_reg  <= block_addr;
            size_reg  <= block_size;
            nsize_reg <= new_size;
            align_reg <= align;
        end
        if (state_reg == S_PREP)
        begin
            // padding to the next multiple of align
            pad_reg   <= (div_rem == '0) ? '0 : align_reg - div_rem;
            avail_reg <= (rtop_reg > top_ptr_reg) ? rtop_reg - top_ptr_reg : '0;
            end_reg   <= {1'b0, addr_reg} + {1'b0, size_reg};
            amt_reg   <= (kind_reg == K_TRUNC) ? size_reg - nsize_reg : size_reg;
        end
        if (exec_fire)
        begin
            status_reg      <= ev_status;
            result_addr_reg <= ev_addr;
            result_size_reg <= ev_size;
            used_bytes_reg  <= ev_top - bottom_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign result_addr = result_addr_reg;
    assign result_size = result_size_reg;
    assign used_bytes  = used_bytes_reg;

    `SRA_ASSERT_NOW(a_div_done_in_div, clk, rst_n, div_stat.done, state_reg == S_DIV, "remainder done outside divide state")
    `SRA_ASSERT_NEXT(a_alloc_divides, clk, rst_n, in_fire && kind == K_ALLOC && align_ok_in, state_reg == S_DIV && div_stat.busy, "legal allocate skipped the remainder unit")
    `SRA_ASSERT_NEXT(a_bad_keeps_state, clk, rst_n, exec_fire && ev_status != ST_OK && !cfg_wr_en, $stable(top_ptr_reg) && $stable(low_mark_reg) && $stable(live_reg), "failed request changed pointers")

endmodule

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import sra_pkg::*;

    // kind code the block does not define, flagged as a bad request
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // generous watchdog, far above the slowest legal run
    localparam int CYCLE_LIMIT = 1000000;
    // long output hold used to back the block up
    localparam int HOLD_CYCLES = 300;
    // percent of cycles each side idles at random
    localparam int IDLE_PCT    = 21;

    // predicted response of one request
    typedef struct packed {
        logic [1:0] status;
        addr_t      addr;
        addr_t      size;
        addr_t      used;
    } alloc_result_t;

    // dut signals, inputs known from time zero
    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic       in_ready;
    logic [1:0] kind        = '0;
    addr_t      block_addr  = '0;
    addr_t      block_size  = '0;
    addr_t      new_size    = '0;
    align_t     align       = align_t'(1);
    logic       out_valid;
    logic       out_ready   = 1'b0;
    logic [1:0] status;
    addr_t      result_addr;
    addr_t      result_size;
    addr_t      used_bytes;
    logic       cfg_wr_en   = 1'b0;
    logic       cfg_index   = 1'b0;
    addr_t      cfg_data    = '0;

    // allocator shadow state, mirrors the block after each transfer
    addr_t rgn_bottom  = '0;
    addr_t rgn_ceiling = '0;
    addr_t top_ptr     = '0;
    addr_t low_mark    = '0;
    addr_t live_bytes  = '0;

    // blocks granted and not yet freed, used to build well-formed traffic
    addr_t live_addr [$];
    addr_t live_size [$];

    // responses still owed by the block, oldest first
    alloc_result_t pending_results [$];

    // bookkeeping
    int  mismatches     = 0;
    int  results_seen   = 0;
    int  requests_sent  = 0;
    int  n_granted      = 0;
    int  n_refused      = 0;
    int  n_flagged      = 0;
    int  region_setups  = 0;
    int  cycle_count    = 0;
    bit  steady         = 1'b0;
    bit  hold_request   = 1'b0;
    int  hold_left      = 0;

    stack_region_allocator DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .block_addr  (block_addr),
        .block_size  (block_size),
        .new_size    (new_size),
        .align       (align),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .result_addr (result_addr),
        .result_size (result_size),
        .used_bytes  (used_bytes),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // 4 ns clock
    initial
    begin
        forever #2 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d responses outstanding",
                     cycle_count, pending_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side: random idling, or a long counted hold when asked for
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_request)
        begin
            out_ready    <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            hold_request <= 1'b0;
        end
        else
        begin
            out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // compare every response transfer against the oldest prediction
    always @(posedge clk)
    begin : response_check
        alloc_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response: status %0d addr %h size %h used %h",
                             status, result_addr, result_size, used_bytes);
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status || result_addr !== want.addr ||
                    result_size !== want.size || used_bytes !== want.used)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch on response %0d:", results_seen);
                        $display("  expected status %0d addr %h size %h used %h",
                                 want.status, want.addr, want.size, want.used);
                        $display("  actual   status %0d addr %h size %h used %h",
                                 status, result_addr, result_size, used_bytes);
                    end
                end
            end
        end
    end

    // shadow allocator: applies one request and returns the response it owes
    function automatic alloc_result_t predict_allocator(input logic [1:0] k,
                                                        input addr_t a, input addr_t n,
                                                        input addr_t nn, input align_t al);
        alloc_result_t   res;
        logic [ADDR_W:0] blk_sum;
        addr_t           blk_stop;
        addr_t           used;
        addr_t           pad;
        addr_t           avail;
        addr_t           shrink;
        logic            flag_bad;
        res      = '0;
        flag_bad = 1'b0;
        // block end with a carry bit, a set carry means it runs off the address range
        blk_sum  = {1'b0, a} + {1'b0, n};
        blk_stop = blk_sum[ADDR_W-1:0];
        case (k)
            K_ALLOC:
            begin
                if (al == 0 || al > ALIGN_MAX)
                    flag_bad = 1'b1;
                else
                begin
                    // pad so that the used size lands on a multiple of align
                    used  = top_ptr - rgn_bottom;
                    pad   = (al - used % al) % al;
                    avail = (rgn_ceiling > top_ptr) ? rgn_ceiling - top_ptr : '0;
                    if (n > avail || pad > avail - n)
                        res.status = ST_NOSPACE;
                    else
                    begin
                        res.status = ST_OK;
                        res.addr   = top_ptr + pad;
                        res.size   = n;
                        // no holes yet: the mark tracks the top
                        if (low_mark == top_ptr)
                            low_mark = low_mark + pad + n;
                        else
                            live_bytes = live_bytes + pad + n;
                        top_ptr = top_ptr + pad + n;
                    end
                end
            end
            K_TRUNC:
            begin
                if (nn > n || a < rgn_bottom || blk_sum[ADDR_W] || blk_stop > top_ptr)
                    flag_bad = 1'b1;
                else
                begin
                    // only a block ending at the top gives space back
                    if (blk_stop == top_ptr)
                    begin
                        shrink = n - nn;
                        if (low_mark != top_ptr && live_bytes < shrink)
                            flag_bad = 1'b1;
                        else
                        begin
                            if (low_mark == top_ptr)
                                low_mark = low_mark - shrink;
                            else
                                live_bytes = live_bytes - shrink;
                            top_ptr = top_ptr - shrink;
                        end
                    end
                    if (!flag_bad)
                    begin
                        res.status = ST_OK;
                        res.addr   = a;
                        res.size   = nn;
                    end
                end
            end
            K_DEALLOC:
            begin
                if (a < rgn_bottom || blk_sum[ADDR_W] || blk_stop > top_ptr)
                    flag_bad = 1'b1;
                else if (blk_stop == top_ptr)
                begin
                    // pop of the top block
                    if (low_mark != top_ptr && live_bytes < n)
                        flag_bad = 1'b1;
                    else
                    begin
                        if (low_mark == top_ptr)
                            low_mark = low_mark - n;
                        else
                            live_bytes = live_bytes - n;
                        top_ptr = top_ptr - n;
                    end
                end
                else if (blk_stop == low_mark)
                    low_mark = low_mark - n;
                else if (blk_stop > low_mark)
                begin
                    // hole above the mark
                    if (live_bytes < n)
                        flag_bad = 1'b1;
                    else
                        live_bytes = live_bytes - n;
                end
                else
                begin
                    // hole below the mark: the mark drops to the block start
                    live_bytes = live_bytes + (low_mark - a) - n;
                    low_mark   = a;
                end
                if (!flag_bad)
                begin
                    res.status = ST_OK;
                    // nothing live above the mark: top falls back
                    if (live_bytes == 0)
                        top_ptr = low_mark;
                end
            end
            default:
                flag_bad = 1'b1;
        endcase
        if (flag_bad)
        begin
            res.status = ST_BAD;
            res.addr   = '0;
            res.size   = '0;
        end
        res.used = top_ptr - rgn_bottom;
        case (res.status)
            ST_OK:      n_granted++;
            ST_NOSPACE: n_refused++;
            default:    n_flagged++;
        endcase
        return res;
    endfunction

    // one request transfer; the prediction is taken at the accepting edge
    task automatic send_request(input logic [1:0] k, input addr_t a, input addr_t n,
                                input addr_t nn, input align_t al,
                                output alloc_result_t res);
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
            @(negedge clk);
        in_valid   <= 1'b1;
        kind       <= k;
        block_addr <= a;
        block_size <= n;
        new_size   <= nn;
        align      <= al;
        do
            @(posedge clk);
        while (!in_ready);
        res = predict_allocator(k, a, n, nn, al);
        pending_results.push_back(res);
        requests_sent++;
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // wait until every owed response has come back and the block has settled
    task automatic wait_idle();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // register write, only while the block is idle
    task automatic write_reg(input logic idx, input addr_t val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_BOTTOM)
        begin
            // a new bottom restarts the region
            rgn_bottom = val;
            top_ptr    = val;
            low_mark   = val;
            live_bytes = '0;
            live_addr.delete();
            live_size.delete();
            region_setups++;
        end
        else
            rgn_ceiling = val;
    endtask

    // mostly well-formed alloc / free / truncate traffic over tracked blocks,
    // with a slice of raw noise and off-by-one frees and truncates
    task automatic random_traffic(input int count);
        alloc_result_t res;
        logic [1:0]    k;
        addr_t         a;
        addr_t         n;
        addr_t         nn;
        align_t        al;
        addr_t         room;
        int            pick;
        int            idx;
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            idx  = -1;
            a    = $urandom;
            nn   = $urandom;
            al   = align_t'(1);
            if (pick < 45 || live_addr.size() == 0)
            begin
                k    = K_ALLOC;
                room = (rgn_ceiling > top_ptr) ? rgn_ceiling - top_ptr : '0;
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: n = $urandom_range(0, 64);
                    6, 7:             n = $urandom_range(0, 4096);
                    8:                n = room + $urandom_range(0, 1); // exact fit or one over
                    default:          n = $urandom;
                endcase
                case ($urandom_range(0, 19))
                    0:       al = $urandom_range(0, 1) ? align_t'(0)
                                  : align_t'($urandom_range(ALIGN_MAX + 1, 8191));
                    1, 2, 3: al = align_t'($urandom_range(1, ALIGN_MAX));
                    default: al = align_t'(1 << $urandom_range(0, 12));
                endcase
            end
            else if (pick < 92)
            begin
                // top block half the time so pops are common
                idx = $urandom_range(0, 1) ? live_addr.size() - 1
                                           : $urandom_range(0, live_addr.size() - 1);
                a   = live_addr[idx];
                n   = live_size[idx];
                if (pick < 80)
                    k = K_DEALLOC;
                else
                begin
                    k  = K_TRUNC;
                    nn = $urandom_range(0, n);
                end
            end
            else if (pick < 96 && live_addr.size() != 0)
            begin
                // near-miss on a tracked block: size or start off by one
                idx = $urandom_range(0, live_addr.size() - 1);
                k   = $urandom_range(0, 1) ? K_TRUNC : K_DEALLOC;
                a   = live_addr[idx] - addr_t'($urandom_range(0, 1));
                n   = live_size[idx] + addr_t'($urandom_range(0, 1));
                nn  = $urandom_range(0, 1) ? n + 1 : addr_t'($urandom_range(0, 8));
                idx = -1;
            end
            else
            begin
                k  = 2'($urandom_range(0, 3));
                n  = $urandom;
                al = align_t'($urandom_range(0, 8191));
            end
            send_request(k, a, n, nn, al, res);
            if (res.status == ST_OK)
            begin
                if (k == K_ALLOC)
                begin
                    live_addr.push_back(res.addr);
                    live_size.push_back(n);
                end
                else if (idx >= 0 && k == K_DEALLOC)
                begin
                    live_addr.delete(idx);
                    live_size.delete(idx);
                end
                else if (idx >= 0 && k == K_TRUNC)
                    live_size[idx] = nn;
            end
        end
    endtask

    // hand-picked requests: field extremes, every kind, each error path
    task automatic test_directed();
        alloc_result_t res;
        addr_t         b0;
        addr_t         b1;
        addr_t         b2;
        // empty region straight out of reset
        send_request(K_ALLOC, '0, '0, '0, align_t'(1), res);
        send_request(K_ALLOC, '0, '1, '0, align_t'(ALIGN_MAX), res);
        send_request(KIND_UNUSED, '1, '1, '1, '1, res);
        send_request(K_ALLOC, '0, addr_t'(1), '0, align_t'(0), res);
        send_request(K_ALLOC, '0, addr_t'(1), '0, align_t'(ALIGN_MAX + 1), res);
        wait_idle();
        write_reg(REG_TOP, 32'h0000_2000);
        write_reg(REG_BOTTOM, 32'h0000_1000);
        // three blocks, the second one padded
        send_request(K_ALLOC, '0, addr_t'(16), '0, align_t'(1), res);
        b0 = res.addr;
        send_request(K_ALLOC, '0, addr_t'(32), '0, align_t'(64), res);
        b1 = res.addr;
        send_request(K_ALLOC, '0, addr_t'(8), '0, align_t'(1), res);
        b2 = res.addr;
        // hole in the middle, then shrink the top block with a hole pending
        send_request(K_DEALLOC, b1, addr_t'(32), '0, align_t'(1), res);
        send_request(K_TRUNC, b2, addr_t'(8), addr_t'(4), align_t'(1), res);
        // shrink below the top gives nothing back
        send_request(K_TRUNC, b0, addr_t'(16), '0, align_t'(1), res);
        // bad truncates and frees
        send_request(K_TRUNC, b0, addr_t'(4), addr_t'(8), align_t'(1), res);
        send_request(K_TRUNC, 32'h0000_0ff0, addr_t'(16), '0, align_t'(1), res);
        send_request(K_DEALLOC, 32'hffff_fff0, addr_t'(32), '0, align_t'(1), res);
        send_request(K_DEALLOC, b2, addr_t'(256), '0, align_t'(1), res);
        // pop of the top block, then a zero-size free below the top
        send_request(K_DEALLOC, b2, addr_t'(4), '0, align_t'(1), res);
        send_request(K_DEALLOC, b0, '0, '0, align_t'(1), res);
        // large padding, exact fill, then one byte over
        send_request(K_ALLOC, '0, addr_t'(256), '0, align_t'(ALIGN_MAX), res);
        send_request(K_ALLOC, '0, rgn_ceiling - top_ptr, '0, align_t'(1), res);
        send_request(K_ALLOC, '0, addr_t'(1), '0, align_t'(1), res);
        // region end moved below the top pointer leaves no room
        wait_idle();
        write_reg(REG_TOP, 32'h0000_1000);
        send_request(K_ALLOC, '0, '0, '0, align_t'(ALIGN_MAX), res);
        send_request(K_ALLOC, '0, '0, '0, align_t'(1), res);
        send_request(K_DEALLOC, '1, '0, '0, align_t'(1), res);
    endtask

    // several region settings, extremes included, with a mid-phase end move
    task automatic test_random_phases();
        addr_t bottoms [6];
        addr_t tops    [6];
        bottoms[0] = 32'h0000_1000; tops[0] = 32'h0001_1000;
        bottoms[1] = 32'h0000_0000; tops[1] = 32'hffff_ffff;
        bottoms[2] = 32'hffff_f000; tops[2] = 32'hffff_ffff;
        bottoms[3] = 32'h0000_0100; tops[3] = 32'h0000_0200;
        bottoms[4] = 32'h8000_0000; tops[4] = 32'h0000_0010;
        bottoms[5] = $urandom;
        tops[5]    = bottoms[5] + addr_t'($urandom_range(0, 32'h0001_0000));
        for (int p = 0; p < 6; p++)
        begin
            wait_idle();
            write_reg(REG_TOP, tops[p]);
            write_reg(REG_BOTTOM, bottoms[p]);
            random_traffic(100);
            // only the end moves, pointers stay put
            wait_idle();
            write_reg(REG_TOP, top_ptr + addr_t'($urandom_range(0, 512)));
            random_traffic(100);
        end
    endtask

    // receiver holds off while the sender keeps offering requests
    task automatic test_output_stall();
        wait_idle();
        write_reg(REG_TOP, 32'h0010_0000);
        write_reg(REG_BOTTOM, 32'h0000_0000);
        hold_request = 1'b1;
        random_traffic(12);
    endtask

    // sender stops until every owed response is back, several times over
    task automatic test_sender_pause();
        repeat (5)
        begin
            random_traffic($urandom_range(1, 6));
            wait_idle();
        end
    endtask

    // no idling on either side
    task automatic test_steady_stream();
        steady = 1'b1;
        random_traffic(100);
        steady = 1'b0;
    endtask

    initial
    begin : stimulus
        // reset held low from the start, released on a falling edge
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_phases();
        test_output_stall();
        test_sender_pause();
        test_steady_stream();

        wait_idle();
        repeat (40) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            mismatches += pending_results.size();
            $display("%0d responses never arrived", pending_results.size());
        end

        $display("%0d requests over %0d region setups: %0d granted, %0d refused, %0d flagged",
                 requests_sent, region_setups, n_granted, n_refused, n_flagged);
        $display("%0d responses checked, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
